// ===== sv/bpfa_pkg.sv =====
// bpfa_pkg: shared types and constants of the bitmap page frame allocator
// used by bpfa_ctrl, bpfa_dp, the top level and the checker
// no dependencies
package bpfa_pkg;

	// geometry of the page bitmap
	localparam int NUM_PAGES    = 65536;
	localparam int PAGE_SHIFT   = 12;
	localparam int BITMAP_BYTES = (NUM_PAGES + 7) / 8;
	localparam int BYTE_W       = $clog2(BITMAP_BYTES);
	localparam int PTR_W        = BYTE_W + 1;
	localparam int ADDR_W       = 32;
	localparam int PAGE_NUM_W   = ADDR_W - PAGE_SHIFT;
	localparam int CFG_W        = 17;

	localparam logic [7:0] FULL_BYTE = 8'hFF;

	// request codes
	localparam logic [1:0] REQ_INIT  = 2'd0;
	localparam logic [1:0] REQ_ALLOC = 2'd1;
	localparam logic [1:0] REQ_FREE  = 2'd2;

	// response status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NO_PAGE = 2'd1;
	localparam logic [1:0] STATUS_RANGE   = 2'd2;

	// configuration register indexes
	localparam logic CFG_KERN_PAGE = 1'b0;
	localparam logic CFG_RAM_END   = 1'b1;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [ADDR_W-1:0] free_address;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] page_address;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INIT,
		ST_ALLOC_RD,
		ST_ALLOC_CHK,
		ST_FREE_RD,
		ST_FREE_WR
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic ptr_zero;
		logic scan_load;
		logic sweep_wr;
		logic sweep_init;
		logic hint_init;
		logic scan_rd;
		logic scan_next;
		logic alloc_wr;
		logic alloc_fail;
		logic free_rd;
		logic free_wr;
		logic rsp_ok;
		logic rsp_range;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [1:0] in_req_type;
		logic       in_free_oob;
		logic       sweep_last;
		logic       scan_end;
		logic       byte_full;
	} dp_sts_t;

endpackage

// ===== sv/bpfa_dp.sv =====
// bpfa_dp: bitmap memory, sweep and scan pointer, search hint,
// request and response registers, configuration registers
// depends on bpfa_pkg
module bpfa_dp import bpfa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  req_t             req,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  dp_cmd_t          cmd,
	output dp_sts_t          sts,
	output logic             done,
	output rsp_t             rsp
);

	logic [7:0]        mem [BITMAP_BYTES];
	logic [7:0]        rd_q;
	logic [15:0]       kpage_q;
	logic [16:0]       ram_end_q;
	logic [PTR_W-1:0]  ptr_q;
	logic [PTR_W-1:0]  hint_q;
	logic [BYTE_W-1:0] fbyte_q;
	logic [2:0]        fbit_q;
	logic              done_q;
	rsp_t              rsp_q;

	logic [PAGE_NUM_W-1:0] in_page;
	logic [BYTE_W-1:0]     ptr_idx;
	logic [BYTE_W-1:0]     kbyte;
	logic [PTR_W-1:0]      rbyte;
	logic [7:0]            sweep_val;
	logic [2:0]            zero_bit;
	logic [7:0]            alloc_byte;
	logic [7:0]            free_byte;
	logic                  mem_we;
	logic [BYTE_W-1:0]     mem_wa;
	logic [7:0]            mem_wd;
	logic                  mem_re;
	logic [BYTE_W-1:0]     mem_ra;
	logic [PAGE_NUM_W-1:0] alloc_page;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kpage_q   <= '0;
			ram_end_q <= 17'h10000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KERN_PAGE: kpage_q   <= cfg_wdata[15:0];
				CFG_RAM_END:   ram_end_q <= cfg_wdata[16:0];
				default:       ;
			endcase
		end
	end

	// incoming request decode
	assign in_page = req.free_address[ADDR_W-1:PAGE_SHIFT];
	assign sts.in_req_type = req.req_type;
	assign sts.in_free_oob = ({1'b0, in_page} >= (PAGE_NUM_W+1)'(NUM_PAGES));

	assign ptr_idx = ptr_q[BYTE_W-1:0];
	assign sts.sweep_last = (ptr_idx == BYTE_W'(BITMAP_BYTES - 1));
	assign sts.scan_end   = (ptr_q == PTR_W'(BITMAP_BYTES));
	assign sts.byte_full  = (rd_q == FULL_BYTE);

	// reservation value of the byte under the sweep pointer
	assign kbyte = kpage_q[15:3];
	assign rbyte = ram_end_q[16:3];
	always_comb begin
		sweep_val = '0;
		if (cmd.sweep_init && (ptr_idx <= kbyte || {1'b0, ptr_idx} >= rbyte))
			sweep_val = FULL_BYTE;
	end

	// lowest clear bit of the byte just read
	always_comb begin
		zero_bit = '0;
		for (int i = 7; i >= 0; i--) begin
			if (!rd_q[i])
				zero_bit = 3'(i);
		end
	end

	assign alloc_byte = rd_q | (8'h01 << zero_bit);
	assign free_byte  = rd_q & ~(8'h01 << fbit_q);
	assign alloc_page = PAGE_NUM_W'({ptr_idx, zero_bit});

	// memory port selection
	always_comb begin
		mem_we = 1'b0;
		mem_wa = ptr_idx;
		mem_wd = sweep_val;
		mem_re = 1'b0;
		mem_ra = ptr_idx;
		priority if (cmd.sweep_wr) begin
			mem_we = 1'b1;
		end else if (cmd.alloc_wr) begin
			mem_we = 1'b1;
			mem_wd = alloc_byte;
		end else if (cmd.free_wr) begin
			mem_we = 1'b1;
			mem_wa = fbyte_q;
			mem_wd = free_byte;
		end else if (cmd.scan_rd) begin
			mem_re = 1'b1;
		end else if (cmd.free_rd) begin
			mem_re = 1'b1;
			mem_ra = fbyte_q;
		end
	end

	// bitmap memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			rd_q <= mem[mem_ra];
	end

	// sweep and scan pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.ptr_zero) begin
			ptr_q <= '0;
		end else if (cmd.scan_load) begin
			ptr_q <= hint_q;
		end else if (cmd.sweep_wr || cmd.scan_next) begin
			ptr_q <= ptr_q + PTR_W'(1);
		end
	end

	// every byte below the hint is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hint_q <= '0;
		end else if (cmd.hint_init) begin
			hint_q <= PTR_W'(kbyte) + PTR_W'(1);
		end else if (cmd.alloc_wr) begin
			hint_q <= (alloc_byte == FULL_BYTE) ? ptr_q + PTR_W'(1) : ptr_q;
		end else if (cmd.alloc_fail) begin
			hint_q <= ptr_q;
		end else if (cmd.free_wr && ({1'b0, fbyte_q} < hint_q)) begin
			hint_q <= {1'b0, fbyte_q};
		end
	end

	// free target latched at transfer
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			fbyte_q <= in_page[BYTE_W+2:3];
			fbit_q  <= in_page[2:0];
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= cmd.alloc_wr || cmd.alloc_fail || cmd.free_wr
				|| cmd.rsp_ok || cmd.rsp_range;
	end

	// result payload
	always_ff @(posedge clk) begin
		priority if (cmd.alloc_wr) begin
			rsp_q.status       <= STATUS_OK;
			rsp_q.page_address <= ADDR_W'(alloc_page) << PAGE_SHIFT;
		end else if (cmd.alloc_fail) begin
			rsp_q.status       <= STATUS_NO_PAGE;
			rsp_q.page_address <= '0;
		end else if (cmd.rsp_range) begin
			rsp_q.status       <= STATUS_RANGE;
			rsp_q.page_address <= '0;
		end else if (cmd.free_wr || cmd.rsp_ok) begin
			rsp_q.status       <= STATUS_OK;
			rsp_q.page_address <= '0;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== sv/bpfa_ctrl.sv =====
// bpfa_ctrl: state machine sequencing clear, init sweep, alloc scan
// and free read-modify-write
// depends on bpfa_pkg
module bpfa_ctrl import bpfa_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  dp_sts_t sts,
	output dp_cmd_t cmd,
	output logic    busy
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_nxt;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.sweep_last)
					state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					unique case (sts.in_req_type)
						REQ_INIT:  state_nxt = ST_INIT;
						REQ_ALLOC: state_nxt = ST_ALLOC_RD;
						REQ_FREE:  state_nxt = sts.in_free_oob ? ST_IDLE : ST_FREE_RD;
						default:   state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_INIT: begin
				if (sts.sweep_last)
					state_nxt = ST_IDLE;
			end
			ST_ALLOC_RD:  state_nxt = sts.scan_end ? ST_IDLE : ST_ALLOC_CHK;
			ST_ALLOC_CHK: state_nxt = sts.byte_full ? ST_ALLOC_RD : ST_IDLE;
			ST_FREE_RD:   state_nxt = ST_FREE_WR;
			ST_FREE_WR:   state_nxt = ST_IDLE;
			default:      state_nxt = ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.sweep_wr = 1'b1;
			end
			ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					unique case (sts.in_req_type)
						REQ_INIT:  cmd.ptr_zero = 1'b1;
						REQ_ALLOC: cmd.scan_load = 1'b1;
						REQ_FREE:  cmd.rsp_range = sts.in_free_oob;
						default:   cmd.rsp_ok = 1'b1;
					endcase
				end
			end
			ST_INIT: begin
				cmd.sweep_wr   = 1'b1;
				cmd.sweep_init = 1'b1;
				if (sts.sweep_last) begin
					cmd.hint_init = 1'b1;
					cmd.rsp_ok    = 1'b1;
				end
			end
			ST_ALLOC_RD: begin
				if (sts.scan_end)
					cmd.alloc_fail = 1'b1;
				else
					cmd.scan_rd = 1'b1;
			end
			ST_ALLOC_CHK: begin
				if (sts.byte_full)
					cmd.scan_next = 1'b1;
				else
					cmd.alloc_wr = 1'b1;
			end
			ST_FREE_RD: cmd.free_rd = 1'b1;
			ST_FREE_WR: cmd.free_wr = 1'b1;
			default:    ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== sv/bitmap_page_frame_allocator.sv =====
// bitmap_page_frame_allocator: top level of the page frame allocator
// instantiates bpfa_ctrl and bpfa_dp; depends on bpfa_pkg
//
// Usage:
//   request channel: a request transfers on a rising edge with start high and
//   busy low; req carries the request code and, for a free, the address.
//   result channel: done is high for exactly one cycle with rsp valid; every
//   request gives exactly one result and the receiver cannot hold it off.
//   config port: cfg_we writes cfg_wdata to register cfg_index (0 kernel end
//   page, 1 ram end page) at the clock edge; write only while idle.
// Steps per request (transfer edge to the result):
//   unused code or out-of-range free: result in the next cycle
//   free: bitmap byte read, then write back, then the result
//   alloc: a read and a check per byte from the search hint, n = full bytes
//     skipped, up to the bitmap end when no page is free; the hint keeps n small
//   init: one bitmap byte written per cycle, then the result
// The bitmap memory has one write and one read port, which sets these
// steps; one request is worked on at a time.
// Reset: arst_n clears control state, then a clearing pass writes all 8192
// bitmap bytes to zero with busy high; config writes are taken during
// that pass.
module bitmap_page_frame_allocator import bpfa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  req_t             req,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	output logic             done,
	output rsp_t             rsp
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencer
	bpfa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// bitmap and registers
	bpfa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.done      (done),
		.rsp       (rsp)
	);

endmodule

// ===== sv/bpfa_checker.sv =====
// bpfa_checker: port-level assertions for the page frame allocator
// bound to bitmap_page_frame_allocator; depends on bpfa_pkg
module bpfa_checker import bpfa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t req,
	input logic done,
	input rsp_t rsp
);

	logic in_oob;
	assign in_oob = (req.free_address[ADDR_W-1:PAGE_SHIFT] >= PAGE_NUM_W'(NUM_PAGES));

	// status code stays within the defined set
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status == STATUS_OK || rsp.status == STATUS_NO_PAGE
			|| rsp.status == STATUS_RANGE))
		else $error("undefined status code");

	// failures carry a zero address
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != STATUS_OK |-> rsp.page_address == '0)
		else $error("nonzero address on failed result");

	// returned addresses are page aligned
	a_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.page_address[PAGE_SHIFT-1:0] == '0)
		else $error("unaligned page address");

	// an out-of-range free answers in the next cycle
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.req_type == REQ_FREE
			&& (req.free_address[ADDR_W-1:PAGE_SHIFT] >= PAGE_NUM_W'(NUM_PAGES))
		|=> done && rsp.status == STATUS_RANGE)
		else $error("out-of-range free not flagged");

	// init, alloc and in-range free keep the block busy afterwards
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.req_type == REQ_INIT || req.req_type == REQ_ALLOC
			|| (req.req_type == REQ_FREE && !in_oob))
		|=> busy)
		else $error("busy not raised after transfer");

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_bpfa_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.rsp    (rsp)
);
